// File: design/ahgs_pkg.sv
`default_nettype none
package ahgs_pkg;

    // weights are Q0.16, the largest one needs 13 bits
    localparam int WEIGHT_W = 13;
    // taps beyond this offset carry zero weight
    localparam int MAX_REACH = 5;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_WALK,
        ST_WAIT,
        ST_HOLD,
        ST_CLEAR
    } state_e;

    typedef struct packed {
        logic [1:0]        cmd;
        logic signed [15:0] angle;
        logic [8:0]        bin;
    } in_req_t;

    typedef struct packed {
        logic [15:0] plain_count;
        logic [31:0] smoothed_value;
    } out_rsp_t;

    // control that travels with each memory read of a smoothing walk
    typedef struct packed {
        logic                valid;
        logic                hit;
        logic                first;
        logic                center;
        logic                last;
        logic [WEIGHT_W-1:0] weight;
    } tap_ctl_t;

    function automatic logic [WEIGHT_W-1:0] gauss_weight(input logic [3:0] tap_off);
        logic [WEIGHT_W-1:0] w;
        unique case (tap_off)
            4'd0:    w = 13'd7168;
            4'd1:    w = 13'd7026;
            4'd2:    w = 13'd6617;
            4'd3:    w = 13'd5987;
            4'd4:    w = 13'd5205;
            4'd5:    w = 13'd4348;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: design/ahgs_chan_if.sv
`default_nettype none
interface ahgs_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/ahgs_bin_mem.sv
`default_nettype none
module ahgs_bin_mem #(
    parameter int DEPTH  = 360,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 9
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: design/ahgs_mac.sv
`default_nettype none
module ahgs_mac #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ahgs_pkg::tap_ctl_t     tap,
    input  wire logic [COUNT_BITS-1:0]  rd_data,
    output logic                        done,
    output logic [15:0]                 plain,
    output logic [31:0]                 smoothed
);

    localparam int PROD_W = COUNT_BITS + ahgs_pkg::WEIGHT_W;
    localparam int ACC_W  = PROD_W + 4;

    ahgs_pkg::tap_ctl_t      s1_reg;
    logic                    s2_valid_reg;
    logic                    s2_first_reg;
    logic                    s2_last_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [COUNT_BITS-1:0]   cnt_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic                    done_reg;
    logic [63:0]             acc_wide;
    logic [63:0]             cnt_wide;

    // control path
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '0;
            s2_valid_reg <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_reg       <= tap;
            s2_valid_reg <= s1_reg.valid;
            s2_first_reg <= s1_reg.first;
            s2_last_reg  <= s1_reg.last;
            done_reg     <= s2_valid_reg && s2_last_reg;
        end
    end

    // multiply, neighbours out of range add nothing
    always_ff @(posedge clk)
    begin
        if (s1_reg.valid)
        begin
            if (s1_reg.hit)
            begin
                prod_reg <= PROD_W'(rd_data) * PROD_W'(s1_reg.weight);
            end
            else
            begin
                prod_reg <= '0;
            end
            if (s1_reg.center)
            begin
                cnt_reg <= rd_data;
            end
        end
    end

    // accumulate
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            if (s2_first_reg)
            begin
                acc_reg <= ACC_W'(prod_reg);
            end
            else
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    assign acc_wide = 64'(acc_reg);
    assign cnt_wide = 64'(cnt_reg);
    assign smoothed = (|acc_wide[63:32]) ? '1 : acc_wide[31:0];
    assign plain    = (|cnt_wide[63:16]) ? '1 : cnt_wide[15:0];
    assign done     = done_reg;

endmodule
`default_nettype wire

// File: design/angle_histogram_gauss_smooth_unit.sv
`default_nettype none
// Angle histogram with Gaussian smoothing. Each request carries a command:
// add floors a signed Q.6 angle in degrees to a one-degree bin and bumps that
// bin's saturating counter (negative angles and bins past NUM_BINS are
// dropped), read returns one response with the bin's raw count and its
// smoothed value (normalized Gaussian, sigma 5, Q0.16 weights, up to eleven
// taps, zero beyond either end, 16 fraction bits, saturated to 32 bits),
// clear zeroes every bin; add, clear and the unused command give no response.
// All counters live in one synchronous single-read-port memory, which sets
// the timing: one request is worked at a time. An add is accepted, its bin
// read, then written back. A read walks the neighbouring bins from acceptance
// to the response register, one neighbouring bin per cycle through a
// multiply-accumulate pipeline; a read of a bin past NUM_BINS answers zero
// without a walk. A clear writes one bin per cycle, and after reset the same
// clearing pass runs before the first request is taken. A finished response
// waits in an output register, so adds and clears keep flowing while the
// response is held.
module angle_histogram_gauss_smooth_unit #(
    parameter int NUM_BINS   = 360,
    parameter int COUNT_BITS = 16,
    parameter int HALF_WIDTH = 5
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ahgs_chan_if.sink   in_chan,
    ahgs_chan_if.source out_chan
);

    localparam int ADDR_W   = $clog2(NUM_BINS);
    // taps past offset five weigh nothing, so the walk stops there
    localparam int HW_EFF   = (HALF_WIDTH > ahgs_pkg::MAX_REACH) ?
                              ahgs_pkg::MAX_REACH : HALF_WIDTH;
    localparam int TAP_LAST = 2 * HW_EFF;
    localparam int OFF_W    = $clog2(TAP_LAST + 1);
    localparam int IDX_W    = ADDR_W + 2;

    ahgs_pkg::state_e        state_reg, state_next;
    logic [ADDR_W-1:0]       bin_reg, bin_next;
    logic [OFF_W-1:0]        off_reg, off_next;
    logic [ADDR_W-1:0]       clr_reg, clr_next;
    logic                    zero_reg, zero_next;
    logic                    out_valid_reg, out_valid_next;
    ahgs_pkg::out_rsp_t      out_data_reg, out_data_next;

    // request decode
    ahgs_pkg::cmd_e          req_cmd;
    logic [8:0]              angle_bin;
    logic                    add_ok;
    logic                    read_ok;
    logic                    load;

    // memory controls
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [COUNT_BITS-1:0]   mem_wdata;
    logic [ADDR_W-1:0]       mem_raddr;
    logic [COUNT_BITS-1:0]   mem_rdata;

    // smoothing walk
    logic signed [IDX_W-1:0] tap_idx;
    logic [OFF_W-1:0]        abs_off;
    ahgs_pkg::tap_ctl_t      tap;
    logic                    mac_done;
    logic [15:0]             mac_plain;
    logic [31:0]             mac_smoothed;

    assign req_cmd   = ahgs_pkg::cmd_e'(in_chan.data.cmd);
    assign angle_bin = in_chan.data.angle[14:6];
    assign add_ok    = !in_chan.data.angle[15] && (32'(angle_bin) < 32'(NUM_BINS));
    assign read_ok   = 32'(in_chan.data.bin) < 32'(NUM_BINS);

    // neighbour index and tap weight for the current walk position
    assign tap_idx = $signed({2'b00, bin_reg}) + $signed(IDX_W'(off_reg))
                     - $signed(IDX_W'(HW_EFF));
    assign abs_off = (off_reg >= OFF_W'(HW_EFF)) ? (off_reg - OFF_W'(HW_EFF))
                                                 : (OFF_W'(HW_EFF) - off_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ahgs_pkg::ST_CLEAR;
            bin_reg       <= '0;
            off_reg       <= '0;
            clr_reg       <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bin_reg       <= bin_next;
            off_reg       <= off_next;
            clr_reg       <= clr_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        off_next       = off_reg;
        clr_next       = clr_reg;
        zero_next      = zero_reg;
        in_chan.ready  = 1'b0;
        load           = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = bin_reg;
        mem_wdata      = '0;
        mem_raddr      = bin_reg;
        tap            = '0;

        unique case (state_reg)
            ahgs_pkg::ST_IDLE:
            begin
                // ready is high throughout idle, so valid alone marks a request
                in_chan.ready = 1'b1;
                if (in_chan.valid)
                begin
                    unique case (req_cmd)
                        ahgs_pkg::CMD_ADD:
                        begin
                            if (add_ok)
                            begin
                                bin_next   = ADDR_W'(32'(angle_bin));
                                state_next = ahgs_pkg::ST_ADD_RD;
                            end
                        end
                        ahgs_pkg::CMD_READ:
                        begin
                            off_next = '0;
                            if (read_ok)
                            begin
                                bin_next   = ADDR_W'(32'(in_chan.data.bin));
                                zero_next  = 1'b0;
                                state_next = ahgs_pkg::ST_WALK;
                            end
                            else
                            begin
                                zero_next  = 1'b1;
                                state_next = ahgs_pkg::ST_HOLD;
                            end
                        end
                        ahgs_pkg::CMD_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = ahgs_pkg::ST_CLEAR;
                        end
                        ahgs_pkg::CMD_NOP:
                        begin
                            state_next = ahgs_pkg::ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ahgs_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ahgs_pkg::ST_ADD_RD:
            begin
                mem_raddr  = bin_reg;
                state_next = ahgs_pkg::ST_ADD_WR;
            end
            ahgs_pkg::ST_ADD_WR:
            begin
                // saturating increment of the fetched counter
                mem_we     = 1'b1;
                mem_waddr  = bin_reg;
                mem_wdata  = (&mem_rdata) ? mem_rdata : (mem_rdata + 1'b1);
                state_next = ahgs_pkg::ST_IDLE;
            end
            ahgs_pkg::ST_WALK:
            begin
                mem_raddr     = tap_idx[ADDR_W-1:0];
                tap.valid     = 1'b1;
                tap.hit       = (tap_idx >= 0) &&
                                (32'(tap_idx) < 32'(NUM_BINS));
                tap.first     = (off_reg == '0);
                tap.center    = (off_reg == OFF_W'(HW_EFF));
                tap.last      = (off_reg == OFF_W'(TAP_LAST));
                tap.weight    = ahgs_pkg::gauss_weight(4'(abs_off));
                off_next      = off_reg + 1'b1;
                if (off_reg == OFF_W'(TAP_LAST))
                begin
                    state_next = ahgs_pkg::ST_WAIT;
                end
            end
            ahgs_pkg::ST_WAIT:
            begin
                if (mac_done)
                begin
                    state_next = ahgs_pkg::ST_HOLD;
                end
            end
            ahgs_pkg::ST_HOLD:
            begin
                // response goes out once the output register is free
                if (!out_valid_reg || out_chan.ready)
                begin
                    load       = 1'b1;
                    state_next = ahgs_pkg::ST_IDLE;
                end
            end
            ahgs_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(NUM_BINS - 1))
                begin
                    state_next = ahgs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ahgs_pkg::ST_IDLE;
            end
        endcase
    end

    // response register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            if (zero_reg)
            begin
                out_data_next = '0;
            end
            else
            begin
                out_data_next.plain_count    = mac_plain;
                out_data_next.smoothed_value = mac_smoothed;
            end
        end
    end

    assign out_chan.valid = out_valid_reg;
    assign out_chan.data  = out_data_reg;

    ahgs_bin_mem #(
        .DEPTH  (NUM_BINS),
        .WIDTH  (COUNT_BITS),
        .ADDR_W (ADDR_W)
    ) u_bin_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ahgs_mac #(
        .COUNT_BITS (COUNT_BITS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .tap      (tap),
        .rd_data  (mem_rdata),
        .done     (mac_done),
        .plain    (mac_plain),
        .smoothed (mac_smoothed)
    );

    // walk results only arrive while the controller waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> state_reg == ahgs_pkg::ST_WAIT)
        else $error("smoothing result outside wait state");

    // memory writes only from add write-back or the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ahgs_pkg::ST_ADD_WR || state_reg == ahgs_pkg::ST_CLEAR))
        else $error("unexpected memory write");

    // clearing pass stays inside the bin range
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ahgs_pkg::ST_CLEAR |-> 32'(clr_reg) < 32'(NUM_BINS))
        else $error("clear address out of range");

    // a loaded response is presented on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("response lost");

endmodule
`default_nettype wire
